>>> rtl/lbcd_pkg.sv
// Shared constants, codes and types for the LRU block cache directory.
// No dependencies; imported by every other file of the block.
package lbcd_pkg;

   localparam int CAPACITY    = 64;
   localparam int COUNT_WIDTH = 32;
   localparam int SLOT_W      = $clog2(CAPACITY);
   localparam int USED_W      = $clog2(CAPACITY + 1);
   localparam int ADDR_W      = 48;
   localparam int FUNC_W      = 2;
   localparam int CFG_W       = 7;
   localparam int OUT_SLOT_W  = 6;
   localparam int OUT_COUNT_W = 32;
   localparam int EXT_W       = (CFG_W > USED_W) ? CFG_W : USED_W;

   localparam logic [CFG_W-1:0]  CFG_RESET  = 7'd64;
   localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOK,
      ST_UPD
   } state_type;

   typedef struct packed {
      logic ready;
      logic look_en;
      logic upd_fire;
   } ctrl_type;

   typedef struct packed {
      logic [ADDR_W-1:0] blk;
      logic [SLOT_W-1:0] oldest_age;
   } cell_look_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] blk;
      logic [SLOT_W-1:0] age_limit;
   } cell_upd_type;

   typedef struct packed {
      logic              match;
      logic              oldest;
      logic [ADDR_W-1:0] tag;
      logic [SLOT_W-1:0] age;
   } cell_stat_type;

endpackage

>>> rtl/lbcd_if.sv
// Request and response channel interfaces of the LRU block cache directory.
// Depends on lbcd_pkg for field widths.
interface lbcd_req_if import lbcd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [FUNC_W-1:0] func;
   logic [ADDR_W-1:0] block_addr;
   logic              fill_after_miss;

   modport source (output valid, output func, output block_addr, output fill_after_miss,
                   input ready);
   modport sink   (input valid, input func, input block_addr, input fill_after_miss,
                   output ready);
endinterface

interface lbcd_rsp_if import lbcd_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic                   hit;
   logic [OUT_SLOT_W-1:0]  slot;
   logic                   evicted;
   logic [ADDR_W-1:0]      evicted_block;
   logic [OUT_COUNT_W-1:0] read_hits;
   logic [OUT_COUNT_W-1:0] read_misses;
   logic [OUT_COUNT_W-1:0] write_hits;
   logic [OUT_COUNT_W-1:0] write_misses;

   modport source (output valid, output hit, output slot, output evicted,
                   output evicted_block, output read_hits, output read_misses,
                   output write_hits, output write_misses, input ready);
   modport sink   (input valid, input hit, input slot, input evicted,
                   input evicted_block, input read_hits, input read_misses,
                   input write_hits, input write_misses, output ready);
endinterface

>>> rtl/lbcd_cell.sv
// One directory slot: block tag, recency rank, tag compare and age update.
// Depends on lbcd_pkg.
module lbcd_cell import lbcd_pkg::*; (
   input  logic          clock,
   input  cell_look_type look,
   input  cell_upd_type  upd,
   input  logic          valid,
   input  logic          target,
   output cell_stat_type stat
);

   logic [ADDR_W-1:0] tag_ff, tag_in;
   logic [SLOT_W-1:0] age_ff, age_in;

   always_comb begin
      tag_in = tag_ff;
      age_in = age_ff;
      if (upd.en) begin
         if (target) begin
            tag_in = upd.blk;
            age_in = '0;
         end else if (valid && (age_ff < upd.age_limit)) begin
            age_in = age_ff + SLOT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      tag_ff <= tag_in;
      age_ff <= age_in;
   end

   assign stat.match  = valid && (tag_ff == look.blk);
   assign stat.oldest = valid && (age_ff == look.oldest_age);
   assign stat.tag    = tag_ff;
   assign stat.age    = age_ff;

endmodule

>>> rtl/lbcd_ctrl.sv
// Sequencer of the directory: accept, lookup cycle, update and result cycle.
// Depends on lbcd_pkg.
module lbcd_ctrl import lbcd_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  logic     out_free,
   output ctrl_type ctrl
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_LOOK;
         end
         ST_LOOK: state_in = ST_UPD;
         ST_UPD: begin
            if (out_free) state_in = req_valid ? ST_LOOK : ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl = '0;
      case (state_ff)
         ST_IDLE: ctrl.ready = 1'b1;
         ST_LOOK: ctrl.look_en = 1'b1;
         ST_UPD: begin
            ctrl.ready    = out_free;
            ctrl.upd_fire = out_free;
         end
         default: ctrl = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

endmodule

>>> rtl/lru_block_cache_directory_top.sv
// Top level of the fully associative LRU block cache directory.
// Depends on lbcd_pkg, lbcd_if, lbcd_cell and lbcd_ctrl.
//
//   channel   direction  handshake          contents
//   req_port  in         valid/ready        func, block_addr, fill_after_miss
//   rsp_port  out        valid/ready        hit, slot, eviction, four counters
//   csr_*     in         csr_wr_en          capacity_in_use (7 bits)
//
// Each transaction is a tag compare across all slots, then the recency update with
// the result loaded into the output register.
// A new transaction is taken when idle, or in the update cycle once the output is free.
// A stalled response holds the block in its update cycle until the output frees.
// Reset empties the directory and clears the counters.
module lru_block_cache_directory_top import lbcd_pkg::*; (
   input logic               clock,
   input logic               reset,
   lbcd_req_if.sink          req_port,
   lbcd_rsp_if.source        rsp_port,
   input logic               csr_wr_en,
   input logic [CFG_W-1:0]   csr_wr_data
);

   ctrl_type          ctrl;
   logic              accept;
   logic              out_free;
   logic [CFG_W-1:0]  csr_ff;
   logic [USED_W-1:0] slots_used_ff;

   logic [FUNC_W-1:0] func_ff;
   logic [ADDR_W-1:0] blk_ff;
   logic              fill_ff;

   cell_look_type     look;
   cell_upd_type      upd;
   cell_stat_type     stat [CAPACITY];
   logic [CAPACITY-1:0] valid;
   logic [CAPACITY-1:0] free_onehot;
   logic [CAPACITY-1:0] match_vec;
   logic [CAPACITY-1:0] oldest_vec;

   logic [SLOT_W-1:0] found_idx, found_age, oldest_idx;
   logic [ADDR_W-1:0] oldest_tag;
   logic [EXT_W-1:0]  cfg_ext, eff_cap;
   logic              full;

   logic                hit_in, evicted_in, grow_in, upd_ok_in;
   logic [SLOT_W-1:0]   slot_in, limit_in;
   logic [ADDR_W-1:0]   evict_tag_in;
   logic [CAPACITY-1:0] target_in;
   logic                inc_rh_in, inc_rm_in, inc_wh_in, inc_wm_in;

   logic                hit_ff, evicted_ff, grow_ff, upd_ok_ff;
   logic [SLOT_W-1:0]   slot_ff, limit_ff;
   logic [ADDR_W-1:0]   evict_tag_ff;
   logic [CAPACITY-1:0] target_ff;
   logic                inc_rh_ff, inc_rm_ff, inc_wh_ff, inc_wm_ff;

   logic [COUNT_WIDTH-1:0] rd_hit_ff, rd_miss_ff, wr_hit_ff, wr_miss_ff;
   logic [COUNT_WIDTH-1:0] rd_hit_in, rd_miss_in, wr_hit_in, wr_miss_in;

   logic                   rsp_valid_ff;
   logic                   rsp_hit_ff, rsp_evicted_ff;
   logic [OUT_SLOT_W-1:0]  rsp_slot_ff;
   logic [ADDR_W-1:0]      rsp_evict_ff;
   logic [OUT_COUNT_W-1:0] rsp_rh_ff, rsp_rm_ff, rsp_wh_ff, rsp_wm_ff;

   assign out_free = !rsp_valid_ff || rsp_port.ready;
   assign accept   = req_port.valid && ctrl.ready;
   assign req_port.ready = ctrl.ready;

   lbcd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .out_free  (out_free),
      .ctrl      (ctrl)
   );

   assign look.blk        = blk_ff;
   assign look.oldest_age = SLOT_W'(slots_used_ff - USED_W'(1));
   assign upd.en          = ctrl.upd_fire && upd_ok_ff;
   assign upd.blk         = blk_ff;
   assign upd.age_limit   = limit_ff;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      assign valid[i]       = slots_used_ff > USED_W'(i);
      assign free_onehot[i] = slots_used_ff == USED_W'(i);
      assign match_vec[i]   = stat[i].match;
      assign oldest_vec[i]  = stat[i].oldest;
      lbcd_cell u_cell (
         .clock  (clock),
         .look   (look),
         .upd    (upd),
         .valid  (valid[i]),
         .target (target_ff[i]),
         .stat   (stat[i])
      );
   end

   always_comb begin
      found_idx  = '0;
      found_age  = '0;
      oldest_idx = '0;
      oldest_tag = '0;
      for (int k = 0; k < CAPACITY; k++) begin
         if (stat[k].match) begin
            found_idx = found_idx | SLOT_W'(k);
            found_age = found_age | stat[k].age;
         end
         if (stat[k].oldest) begin
            oldest_idx = oldest_idx | SLOT_W'(k);
            oldest_tag = oldest_tag | stat[k].tag;
         end
      end
   end

   always_comb begin
      cfg_ext = EXT_W'(csr_ff);
      if (cfg_ext == '0)                     eff_cap = EXT_W'(1);
      else if (cfg_ext > EXT_W'(CAPACITY))   eff_cap = EXT_W'(CAPACITY);
      else                                   eff_cap = cfg_ext;
      full = EXT_W'(slots_used_ff) >= eff_cap;
   end

   always_comb begin
      hit_in       = |match_vec;
      evicted_in   = 1'b0;
      grow_in      = 1'b0;
      upd_ok_in    = 1'b0;
      slot_in      = '0;
      limit_in     = found_age;
      evict_tag_in = '0;
      target_in    = match_vec;
      inc_rh_in    = 1'b0;
      inc_rm_in    = 1'b0;
      inc_wh_in    = 1'b0;
      inc_wm_in    = 1'b0;
      case (func_ff)
         FUNC_READ: begin
            inc_rh_in = hit_in;
            inc_rm_in = !hit_in;
            upd_ok_in = hit_in;
            if (hit_in) slot_in = found_idx;
         end
         FUNC_WRITE: begin
            upd_ok_in = 1'b1;
            inc_wh_in = hit_in && !fill_ff;
            inc_wm_in = !hit_in && !fill_ff;
            if (hit_in) begin
               slot_in = found_idx;
            end else if (full) begin
               evicted_in   = 1'b1;
               evict_tag_in = oldest_tag;
               slot_in      = oldest_idx;
               target_in    = oldest_vec;
               limit_in     = look.oldest_age;
            end else begin
               grow_in   = 1'b1;
               slot_in   = SLOT_W'(slots_used_ff);
               target_in = free_onehot;
               limit_in  = SLOT_W'(slots_used_ff);
            end
         end
         default: begin
            if (hit_in) slot_in = found_idx;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff <= req_port.func;
         blk_ff  <= req_port.block_addr;
         fill_ff <= req_port.fill_after_miss;
      end
      if (ctrl.look_en) begin
         hit_ff       <= hit_in;
         evicted_ff   <= evicted_in;
         grow_ff      <= grow_in;
         upd_ok_ff    <= upd_ok_in;
         slot_ff      <= slot_in;
         limit_ff     <= limit_in;
         evict_tag_ff <= evict_tag_in;
         target_ff    <= target_in;
         inc_rh_ff    <= inc_rh_in;
         inc_rm_ff    <= inc_rm_in;
         inc_wh_ff    <= inc_wh_in;
         inc_wm_ff    <= inc_wm_in;
      end
   end

   assign rd_hit_in  = rd_hit_ff  + COUNT_WIDTH'(inc_rh_ff);
   assign rd_miss_in = rd_miss_ff + COUNT_WIDTH'(inc_rm_ff);
   assign wr_hit_in  = wr_hit_ff  + COUNT_WIDTH'(inc_wh_ff);
   assign wr_miss_in = wr_miss_ff + COUNT_WIDTH'(inc_wm_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff        <= CFG_RESET;
         slots_used_ff <= '0;
         rd_hit_ff     <= '0;
         rd_miss_ff    <= '0;
         wr_hit_ff     <= '0;
         wr_miss_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) csr_ff <= csr_wr_data;
         if (ctrl.upd_fire) begin
            slots_used_ff <= slots_used_ff + USED_W'(grow_ff);
            rd_hit_ff     <= rd_hit_in;
            rd_miss_ff    <= rd_miss_in;
            wr_hit_ff     <= wr_hit_in;
            wr_miss_ff    <= wr_miss_in;
            rsp_valid_ff  <= 1'b1;
         end else if (rsp_port.ready) begin
            rsp_valid_ff  <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.upd_fire) begin
         rsp_hit_ff     <= hit_ff;
         rsp_evicted_ff <= evicted_ff;
         rsp_slot_ff    <= OUT_SLOT_W'(slot_ff);
         rsp_evict_ff   <= evict_tag_ff;
         rsp_rh_ff      <= OUT_COUNT_W'(rd_hit_in);
         rsp_rm_ff      <= OUT_COUNT_W'(rd_miss_in);
         rsp_wh_ff      <= OUT_COUNT_W'(wr_hit_in);
         rsp_wm_ff      <= OUT_COUNT_W'(wr_miss_in);
      end
   end

   assign rsp_port.valid         = rsp_valid_ff;
   assign rsp_port.hit           = rsp_hit_ff;
   assign rsp_port.slot          = rsp_slot_ff;
   assign rsp_port.evicted       = rsp_evicted_ff;
   assign rsp_port.evicted_block = rsp_evict_ff;
   assign rsp_port.read_hits     = rsp_rh_ff;
   assign rsp_port.read_misses   = rsp_rm_ff;
   assign rsp_port.write_hits    = rsp_wh_ff;
   assign rsp_port.write_misses  = rsp_wm_ff;

endmodule

>>> rtl/lbcd_checker.sv
// Port-level checks for the LRU block cache directory, bound to the top level.
// Depends on lbcd_pkg and lru_block_cache_directory_top.
module lbcd_checker import lbcd_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic                   rsp_hit,
   input logic                   rsp_evicted,
   input logic [OUT_SLOT_W-1:0]  rsp_slot,
   input logic [ADDR_W-1:0]      rsp_evicted_block,
   input logic [OUT_COUNT_W-1:0] rsp_read_hits
);

   logic req_fire;
   assign req_fire = req_valid && req_ready;

   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ready)
      else $error("transaction taken on consecutive cycles");

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_fire, 3))
      else $error("response without a matching request transaction");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_evicted |-> !rsp_hit)
      else $error("eviction reported on a hit");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_slot)
         && $stable(rsp_evicted_block) && $stable(rsp_read_hits))
      else $error("stalled response changed");

endmodule

bind lru_block_cache_directory_top lbcd_checker u_lbcd_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_port.valid),
   .req_ready         (req_port.ready),
   .rsp_valid         (rsp_port.valid),
   .rsp_ready         (rsp_port.ready),
   .rsp_hit           (rsp_port.hit),
   .rsp_evicted       (rsp_port.evicted),
   .rsp_slot          (rsp_port.slot),
   .rsp_evicted_block (rsp_port.evicted_block),
   .rsp_read_hits     (rsp_port.read_hits)
);

>>> tb/sv/tb_lru_block_cache_directory_top.sv
// Self-checking testbench for lru_block_cache_directory_top: an LRU directory predictor
// checks hit, slot, eviction and counters on every response. Depends on lbcd_pkg, lbcd_if
// and the RTL of the block.
module tb_lru_block_cache_directory_top;
   import lbcd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [FUNC_W-1:0] FUNC_PROBE = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;
   localparam int CYCLE_LIMIT = 600000;
   localparam int PHASE_ITEMS = 153;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [ADDR_W-1:0] addr;
      logic              fill;
   } dir_req_type;

   typedef struct packed {
      logic                   hit;
      logic [OUT_SLOT_W-1:0]  slot;
      logic                   evicted;
      logic [ADDR_W-1:0]      evicted_block;
      logic [OUT_COUNT_W-1:0] read_hits;
      logic [OUT_COUNT_W-1:0] read_misses;
      logic [OUT_COUNT_W-1:0] write_hits;
      logic [OUT_COUNT_W-1:0] write_misses;
   } dir_rsp_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [CFG_W-1:0] csr_wr_data;

   lbcd_req_if req_port ();
   lbcd_rsp_if rsp_port ();

   lru_block_cache_directory_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_port    (req_port),
      .rsp_port    (rsp_port),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // directory shadow state
   logic [ADDR_W-1:0]      dir_tag [CAPACITY];
   logic [SLOT_W-1:0]      dir_age [CAPACITY];
   int                     dir_used;
   logic [CFG_W-1:0]       cap_reg;
   logic [COUNT_WIDTH-1:0] cnt_rd_hit, cnt_rd_miss, cnt_wr_hit, cnt_wr_miss;

   dir_req_type pending_req_q[$];
   dir_rsp_type expected_rsp_q[$];
   dir_req_type req_next;
   dir_rsp_type rsp_want;

   bit req_taken;
   bit req_calm, rsp_calm;
   int req_gap, rsp_gap, stall_left;
   int hold_marks[$] = '{260, 1000};
   int rsp_seen;
   int error_count;
   int cycle_count;
   int phase_caps[9] = '{127, 64, 1, 100, 8, 2, 77, 64, 33};

   function automatic logic [ADDR_W-1:0] rand_block();
      return {16'($urandom), 32'($urandom)};
   endfunction

   function automatic int idle_gap(bit calm);
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 45);
   endfunction

   function automatic int eff_capacity(int cap);
      if (cap == 0) return 1;
      if (cap > CAPACITY) return CAPACITY;
      return cap;
   endfunction

   function automatic void promote(int s);
      logic [SLOT_W-1:0] a;
      a = dir_age[s];
      for (int i = 0; i < dir_used; i++) begin
         if (i != s && dir_age[i] < a) dir_age[i]++;
      end
      dir_age[s] = '0;
   endfunction

   function automatic dir_rsp_type directory_access(logic [FUNC_W-1:0] op,
                                                    logic [ADDR_W-1:0] blk, logic fill);
      dir_rsp_type r;
      int found;
      int victim;
      r = '0;
      found = -1;
      for (int i = 0; i < dir_used; i++) begin
         if (found < 0 && dir_tag[i] == blk) found = i;
      end
      r.hit = (found >= 0);
      case (op)
         FUNC_READ: begin
            if (found >= 0) begin
               cnt_rd_hit++;
               promote(found);
               r.slot = OUT_SLOT_W'(found);
            end else begin
               cnt_rd_miss++;
            end
         end
         FUNC_WRITE: begin
            if (found >= 0) begin
               if (!fill) cnt_wr_hit++;
               promote(found);
               r.slot = OUT_SLOT_W'(found);
            end else begin
               if (!fill) cnt_wr_miss++;
               if (dir_used >= eff_capacity(cap_reg)) begin
                  victim = 0;
                  for (int i = 1; i < dir_used; i++) begin
                     if (dir_age[i] > dir_age[victim]) victim = i;
                  end
                  r.evicted       = 1'b1;
                  r.evicted_block = dir_tag[victim];
                  dir_tag[victim] = blk;
                  promote(victim);
               end else begin
                  victim = dir_used;
                  for (int i = 0; i < dir_used; i++) dir_age[i]++;
                  dir_tag[victim] = blk;
                  dir_age[victim] = '0;
                  dir_used++;
               end
               r.slot = OUT_SLOT_W'(victim);
            end
         end
         default: begin
            if (found >= 0) r.slot = OUT_SLOT_W'(found);
         end
      endcase
      r.read_hits    = cnt_rd_hit;
      r.read_misses  = cnt_rd_miss;
      r.write_hits   = cnt_wr_hit;
      r.write_misses = cnt_wr_miss;
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      if (error_count < 100)
         $display("mismatch on response %0d: %s got %0h expected %0h", rsp_seen, what, got,
                  want);
      error_count++;
   endtask

   task automatic check_field(string what, logic [63:0] got, logic [63:0] want);
      if (got !== want) report_mismatch(what, got, want);
   endtask

   task automatic queue_req(logic [FUNC_W-1:0] op, logic [ADDR_W-1:0] blk, logic fill);
      dir_req_type it;
      it.func = op;
      it.addr = blk;
      it.fill = fill;
      pending_req_q.push_back(it);
   endtask

   task automatic queue_random_phase(int cap, int n);
      logic [ADDR_W-1:0] pool[$];
      int psize;
      int r;
      dir_req_type it;
      psize = eff_capacity(cap) + $urandom_range(0, 6);
      repeat (psize) pool.push_back(rand_block());
      if ($urandom_range(0, 3) == 0) pool[0] = '0;
      if ($urandom_range(0, 3) == 0) pool[psize-1] = '1;
      repeat (n) begin
         r = $urandom_range(0, 99);
         it.func = (r < 20) ? FUNC_PROBE : (r < 55) ? FUNC_READ :
                   (r < 95) ? FUNC_WRITE : FUNC_SPARE;
         it.addr = ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, psize-1)]
                                                 : rand_block();
         it.fill = ($urandom_range(0, 99) < 30);
         pending_req_q.push_back(it);
      end
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (pending_req_q.size() != 0 || req_port.valid || expected_rsp_q.size() != 0);
   endtask

   task automatic write_capacity(logic [CFG_W-1:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // predictor: capture accepted transactions and register writes
   always @(posedge clock) begin
      if (reset) begin
         dir_used    = 0;
         cap_reg     = CFG_RESET;
         cnt_rd_hit  = '0;
         cnt_rd_miss = '0;
         cnt_wr_hit  = '0;
         cnt_wr_miss = '0;
         req_taken   = 1'b0;
      end else begin
         if (csr_wr_en) cap_reg = csr_wr_data;
         req_taken = req_port.valid && req_port.ready;
         if (req_taken)
            expected_rsp_q.push_back(directory_access(req_port.func, req_port.block_addr,
                                                      req_port.fill_after_miss));
      end
   end

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_port.valid <= 1'b0;
      end else if (!req_port.valid || req_taken) begin
         if (req_gap > 0) begin
            req_port.valid <= 1'b0;
            req_gap--;
         end else if (pending_req_q.size() > 0) begin
            req_next = pending_req_q.pop_front();
            req_port.func            <= req_next.func;
            req_port.block_addr      <= req_next.addr;
            req_port.fill_after_miss <= req_next.fill;
            req_port.valid           <= 1'b1;
            req_gap = idle_gap(req_calm);
            if ($urandom_range(0, 63) == 0) req_calm = !req_calm;
         end else begin
            req_port.valid <= 1'b0;
         end
      end
   end

   // response ready: random stalls plus long hold-offs to back up the block
   always @(negedge clock) begin
      if (reset) begin
         rsp_port.ready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_port.ready <= 1'b0;
         stall_left--;
      end else if (hold_marks.size() > 0 && rsp_seen >= hold_marks[0]) begin
         hold_marks.delete(0);
         rsp_port.ready <= 1'b0;
         stall_left = 80;
      end else if (rsp_gap > 0) begin
         rsp_port.ready <= 1'b0;
         rsp_gap--;
      end else begin
         rsp_port.ready <= 1'b1;
         rsp_gap = ($urandom_range(0, 2) == 0) ? idle_gap(rsp_calm) : 0;
         if ($urandom_range(0, 63) == 0) rsp_calm = !rsp_calm;
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_port.valid && rsp_port.ready) begin
         rsp_seen++;
         if (expected_rsp_q.size() == 0) begin
            report_mismatch("unexpected transaction", 64'(rsp_port.slot), '0);
         end else begin
            rsp_want = expected_rsp_q.pop_front();
            check_field("hit", 64'(rsp_port.hit), 64'(rsp_want.hit));
            check_field("slot", 64'(rsp_port.slot), 64'(rsp_want.slot));
            check_field("evicted", 64'(rsp_port.evicted), 64'(rsp_want.evicted));
            check_field("evicted_block", 64'(rsp_port.evicted_block),
                        64'(rsp_want.evicted_block));
            check_field("read_hits", 64'(rsp_port.read_hits), 64'(rsp_want.read_hits));
            check_field("read_misses", 64'(rsp_port.read_misses),
                        64'(rsp_want.read_misses));
            check_field("write_hits", 64'(rsp_port.write_hits), 64'(rsp_want.write_hits));
            check_field("write_misses", 64'(rsp_port.write_misses),
                        64'(rsp_want.write_misses));
         end
      end
   end

   initial begin
      reset                    = 1'b1;
      csr_wr_en                = 1'b0;
      csr_wr_data              = '0;
      req_port.valid           = 1'b0;
      req_port.func            = '0;
      req_port.block_addr      = '0;
      req_port.fill_after_miss = 1'b0;
      rsp_port.ready           = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty directory, free slots, hits, spare code, fills
      queue_req(FUNC_PROBE, 48'h0, 1'b0);
      queue_req(FUNC_READ, '1, 1'b1);
      queue_req(FUNC_WRITE, 48'h0, 1'b0);
      queue_req(FUNC_WRITE, '1, 1'b0);
      queue_req(FUNC_WRITE, 48'h0, 1'b0);
      queue_req(FUNC_READ, '1, 1'b0);
      queue_req(FUNC_PROBE, 48'h0, 1'b1);
      queue_req(FUNC_SPARE, '1, 1'b1);
      queue_req(FUNC_SPARE, 48'h5, 1'b0);
      queue_req(FUNC_WRITE, 48'h1234_5678_9abc, 1'b1);
      queue_req(FUNC_WRITE, 48'h0, 1'b1);
      queue_req(FUNC_READ, 48'h5, 1'b0);
      wait_drained();

      // capacity below the entries in use
      write_capacity(7'd2);
      queue_req(FUNC_WRITE, 48'haaaa_aaaa_aaaa, 1'b0);
      queue_req(FUNC_WRITE, 48'h5555_5555_5555, 1'b0);
      queue_req(FUNC_READ, 48'haaaa_aaaa_aaaa, 1'b0);
      queue_req(FUNC_WRITE, 48'h7, 1'b1);
      queue_req(FUNC_PROBE, 48'h5555_5555_5555, 1'b0);
      wait_drained();

      // zero capacity behaves as one
      write_capacity(7'd0);
      queue_req(FUNC_WRITE, 48'h9, 1'b0);
      queue_req(FUNC_WRITE, 48'h9, 1'b0);
      queue_req(FUNC_WRITE, 48'ha, 1'b0);
      wait_drained();

      phase_caps[6] = $urandom_range(3, 127);
      foreach (phase_caps[p]) begin
         write_capacity(phase_caps[p][CFG_W-1:0]);
         queue_random_phase(phase_caps[p], PHASE_ITEMS);
         wait_drained();
      end

      repeat (20) @(posedge clock);
      if (expected_rsp_q.size() != 0)
         report_mismatch("missing transactions", 64'(expected_rsp_q.size()), '0);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
